/* rtl/leaf_card_thinner_defines.svh */
// Assertion macros used by the leaf card thinner controller RTL.
`ifndef LEAF_CARD_THINNER_DEFINES_SVH
`define LEAF_CARD_THINNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define LCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lct_pkg.sv */
// Package: widths, reset values, register indexes and shared types of the leaf card thinner.
package lct_pkg;

    localparam int CARD_TRIANGLES_DEF = 2;

    localparam int POS_W      = 32;
    localparam int NRM_W      = 16;
    localparam int TEX_W      = 16;
    localparam int RATE_W     = 17;
    localparam int GROW_W     = 16;
    localparam int ACC_W      = 16;
    localparam int GROW_FRAC  = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [RATE_W-1:0] ONE_Q16       = 17'h10000;
    localparam logic [RATE_W-1:0] KEEP_RATE_RST = ONE_Q16;
    localparam logic [GROW_W-1:0] GROW_RST      = 16'h2000;

    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW      = 1'b1;

    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic signed [TEX_W-1:0] u;
        logic signed [TEX_W-1:0] v;
    } t_vtx;

    typedef struct packed {
        logic take;
        logic card_end;
        logic div_load;
        logic div_step;
        logic rd_en;
        logic mul;
        logic out_load;
        logic out_last;
    } t_cmd;

    typedef struct packed {
        logic keep;
    } t_stat;

endpackage

/* rtl/lct_datapath.sv */
// Datapath: card buffer, position sums, keep accumulator, mean divider and grow/saturate.
module lct_datapath #(
    parameter int CARD_TRIANGLES = lct_pkg::CARD_TRIANGLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lct_pkg::t_cmd                   i_cmd,
    output lct_pkg::t_stat                  o_stat,
    input  logic [$clog2(3*CARD_TRIANGLES)-1:0] i_wr_addr,
    input  logic [$clog2(3*CARD_TRIANGLES)-1:0] i_rd_addr,
    input  logic                            i_cfg_we,
    input  logic [lct_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lct_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  lct_pkg::t_vtx                   i_vtx,
    input  logic                            i_part_start,
    output lct_pkg::t_vtx                   o_vtx,
    output logic                            o_last
);
    import lct_pkg::*;

    localparam int CARD_VERTS = 3 * CARD_TRIANGLES;
    localparam int SLOT_W     = $clog2(CARD_VERTS);
    localparam int SUM_W      = POS_W + SLOT_W;
    localparam int DIV_W      = SUM_W + SLOT_W;
    localparam int NDIG       = (DIV_W + 3) / 4;
    localparam int PAD_W      = 4 * NDIG;
    localparam int T_W        = SLOT_W + 4;
    localparam int DIFF_W     = POS_W + 1;
    localparam int PROD_W     = DIFF_W + GROW_W + 1;
    localparam int SH_W       = PROD_W - GROW_FRAC;

    // Offset makes the dividend non-negative; it is a multiple of the divisor.
    localparam logic [PAD_W-1:0] DIV_OFS = PAD_W'(CARD_VERTS) << (SUM_W - 1);
    localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(1) << (GROW_FRAC - 1);
    localparam logic signed [SH_W-1:0] POS_MAX =
        {{(SH_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
    localparam logic signed [SH_W-1:0] POS_MIN =
        {{(SH_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

    // One radix-16 digit of division by the card size.
    function automatic logic [3+SLOT_W:0] div_digit(input logic [T_W-1:0] t);
        logic [3:0]     d;
        logic [T_W-1:0] r;
        d = '0;
        r = t;
        for (int j = 1; j < 16; j++) begin
            if (t >= T_W'(j * CARD_VERTS)) begin
                d = 4'(j);
                r = t - T_W'(j * CARD_VERTS);
            end
        end
        return {d, r[SLOT_W-1:0]};
    endfunction

    t_vtx                     r_mem [CARD_VERTS];
    t_vtx                     r_rd;
    t_vtx                     r_out;
    logic                     r_last;
    logic [RATE_W-1:0]        r_keep_rate;
    logic [GROW_W-1:0]        r_grow;
    logic [ACC_W-1:0]         r_acc;
    logic [ACC_W-1:0]         n_acc;
    logic [ACC_W-1:0]         acc_base;
    logic [RATE_W-1:0]        rate_eff;
    logic [RATE_W-1:0]        acc_sum;
    logic signed [SUM_W-1:0]  r_sum [3];
    logic signed [SUM_W-1:0]  n_sum [3];
    logic signed [POS_W-1:0]  pos_in [3];
    logic signed [POS_W-1:0]  pos_rd [3];
    logic [POS_W-1:0]         r_mid [3];
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [POS_W-1:0]  grown [3];
    logic signed [GROW_W:0]   grow_s;

    assign pos_in[0] = i_vtx.px;
    assign pos_in[1] = i_vtx.py;
    assign pos_in[2] = i_vtx.pz;
    assign pos_rd[0] = r_rd.px;
    assign pos_rd[1] = r_rd.py;
    assign pos_rd[2] = r_rd.pz;
    assign grow_s    = {1'b0, r_grow};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_rate <= KEEP_RATE_RST;
            r_grow      <= GROW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEEP_RATE: r_keep_rate <= i_cfg_data[RATE_W-1:0];
                CFG_GROW:      r_grow      <= i_cfg_data[GROW_W-1:0];
                default:       ;
            endcase
        end
    end

    // Keep accumulator; bit ACC_W of the sum is the keep decision.
    always_comb begin
        acc_base    = i_part_start ? '0 : r_acc;
        rate_eff    = (r_keep_rate > ONE_Q16) ? ONE_Q16 : r_keep_rate;
        acc_sum     = {1'b0, acc_base} + rate_eff;
        o_stat.keep = acc_sum[ACC_W];
        n_acc       = r_acc;
        if (i_cmd.take) begin
            n_acc = i_cmd.card_end ? acc_sum[ACC_W-1:0] : acc_base;
        end
    end

    // Position sums of the current card.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_sum[a] = r_sum[a];
            if (i_cmd.take) begin
                if (i_cmd.card_end && !o_stat.keep) begin
                    n_sum[a] = '0;
                end else begin
                    n_sum[a] = (i_part_start ? SUM_W'(0) : r_sum[a])
                             + {{SLOT_W{pos_in[a][POS_W-1]}}, pos_in[a]};
                end
            end else if (i_cmd.div_load) begin
                n_sum[a] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= '0;
            end
        end else begin
            r_acc <= n_acc;
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= n_sum[a];
            end
        end
    end

    // Card buffer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_mem[i_wr_addr] <= i_vtx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // Per-axis mean divider and grow about the mean.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [PAD_W-1:0]        r_dvd;
        logic [SLOT_W-1:0]       r_rem;
        logic [T_W-1:0]          t;
        logic [3+SLOT_W:0]       dr;
        logic signed [DIFF_W-1:0] diff;
        logic signed [PROD_W-1:0] rnd;
        logic signed [SH_W-1:0]  shv;
        logic signed [SH_W-1:0]  res;

        assign t  = {r_rem, r_dvd[PAD_W-1 -: 4]};
        assign dr = div_digit(t);

        always_ff @(posedge i_clk) begin
            if (i_cmd.div_load) begin
                r_dvd <= {{(PAD_W-SUM_W){r_sum[a][SUM_W-1]}}, r_sum[a]} + DIV_OFS;
                r_rem <= '0;
            end else if (i_cmd.div_step) begin
                r_dvd    <= r_dvd << 4;
                r_rem    <= dr[SLOT_W-1:0];
                r_mid[a] <= {r_mid[a][POS_W-5:0], dr[3+SLOT_W:SLOT_W]};
            end
        end

        assign diff = {pos_rd[a][POS_W-1], pos_rd[a]}
                    - $signed({r_mid[a][POS_W-1], r_mid[a]});

        always_ff @(posedge i_clk) begin
            if (i_cmd.mul) begin
                r_prod[a] <= diff * grow_s;
            end
        end

        always_comb begin
            rnd = r_prod[a] + ROUND;
            shv = $signed(rnd[PROD_W-1:GROW_FRAC]);
            res = {{(SH_W-POS_W){r_mid[a][POS_W-1]}}, r_mid[a]} + shv;
            if (res > POS_MAX) begin
                grown[a] = POS_MAX[POS_W-1:0];
            end else if (res < POS_MIN) begin
                grown[a] = POS_MIN[POS_W-1:0];
            end else begin
                grown[a] = res[POS_W-1:0];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.px <= grown[0];
            r_out.py <= grown[1];
            r_out.pz <= grown[2];
            r_out.nx <= r_rd.nx;
            r_out.ny <= r_rd.ny;
            r_out.nz <= r_rd.nz;
            r_out.u  <= r_rd.u;
            r_out.v  <= r_rd.v;
            r_last   <= i_cmd.out_last;
        end
    end

    assign o_vtx  = r_out;
    assign o_last = r_last;

endmodule

/* rtl/lct_ctrl.sv */
// Controller: collect, divide and emit sequencing of the leaf card thinner.
`include "leaf_card_thinner_defines.svh"
module lct_ctrl #(
    parameter int CARD_TRIANGLES = lct_pkg::CARD_TRIANGLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_part_start,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lct_pkg::t_cmd                   o_cmd,
    input  lct_pkg::t_stat                  i_stat,
    output logic [$clog2(3*CARD_TRIANGLES)-1:0] o_wr_addr,
    output logic [$clog2(3*CARD_TRIANGLES)-1:0] o_rd_addr
);
    import lct_pkg::*;

    localparam int CARD_VERTS = 3 * CARD_TRIANGLES;
    localparam int SLOT_W     = $clog2(CARD_VERTS);
    localparam int DIV_W      = POS_W + 2 * SLOT_W;
    localparam int NDIG       = (DIV_W + 3) / 4;
    localparam int DIG_W      = $clog2(NDIG);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CARD_VERTS - 1);
    localparam logic [DIG_W-1:0]  LAST_DIG  = DIG_W'(NDIG - 1);

    localparam logic [2:0] S_COLLECT = 3'd0;
    localparam logic [2:0] S_LOAD    = 3'd1;
    localparam logic [2:0] S_DIV     = 3'd2;
    localparam logic [2:0] S_RD      = 3'd3;
    localparam logic [2:0] S_MUL     = 3'd4;
    localparam logic [2:0] S_SAT     = 3'd5;
    localparam logic [2:0] S_HOLD    = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0] r_emit, n_emit;
    logic [DIG_W-1:0]  r_dig, n_dig;
    logic [SLOT_W-1:0] slot_eff;
    logic              take;
    logic              card_end;

    always_comb begin
        n_state  = r_state;
        n_slot   = r_slot;
        n_emit   = r_emit;
        n_dig    = r_dig;
        o_cmd    = '0;
        slot_eff = i_part_start ? '0 : r_slot;
        card_end = (slot_eff == LAST_SLOT);
        take     = i_in_valid && (r_state == S_COLLECT);
        o_cmd.take     = take;
        o_cmd.card_end = take && card_end;
        case (r_state)
            S_COLLECT: begin
                if (take) begin
                    if (card_end) begin
                        n_slot = '0;
                        if (i_stat.keep) begin
                            n_state = S_LOAD;
                        end
                    end else begin
                        n_slot = slot_eff + 1'b1;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_dig          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_dig == LAST_DIG) begin
                    n_emit  = '0;
                    n_state = S_RD;
                end else begin
                    n_dig = r_dig + 1'b1;
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SAT;
            end
            S_SAT: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_last = (r_emit == LAST_SLOT);
                n_state        = S_HOLD;
            end
            S_HOLD: begin
                if (i_out_ready) begin
                    if (r_emit == LAST_SLOT) begin
                        n_state = S_COLLECT;
                    end else begin
                        n_emit  = r_emit + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_slot  <= '0;
            r_emit  <= '0;
            r_dig   <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_emit  <= n_emit;
            r_dig   <= n_dig;
        end
    end

    assign o_in_ready  = (r_state == S_COLLECT);
    assign o_out_valid = (r_state == S_HOLD);
    assign o_wr_addr   = slot_eff;
    assign o_rd_addr   = r_emit;

    `LCT_ASSERT_IMPL(a_ready_valid_excl, i_clk, i_rst_n, o_in_ready, !o_out_valid, "in ready while out valid")
    `LCT_ASSERT_NEXT(a_keep_starts_div, i_clk, i_rst_n, o_cmd.card_end && i_stat.keep, r_state == S_LOAD, "kept card did not start divide")
    `LCT_ASSERT_NEXT(a_drop_clears, i_clk, i_rst_n, o_cmd.card_end && !i_stat.keep, o_in_ready && (r_slot == '0), "dropped card not cleared")
    `LCT_ASSERT_NEXT(a_last_beat_done, i_clk, i_rst_n, o_out_valid && i_out_ready && (r_emit == LAST_SLOT), o_in_ready, "no return to collect after last beat")

endmodule

/* rtl/leaf_card_thinner.sv */
// Top level of the leaf card thinner: controller and datapath.
//
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_ready    i_pos_*, i_norm_*, i_tex_*, i_part_start
//  out      output     o_out_valid / i_out_ready  o_out_x/y/z/nx/ny/nz/u/v, o_card_last
//  cfg      input      i_cfg_we (no stall)        i_cfg_idx, i_cfg_data
//
//  Collect: one input beat per cycle while gathering a card of 3*CARD_TRIANGLES vertices.
//  A kept card then goes through the radix-16 mean divider, a load step and NDIG digit
//  steps, NDIG being ceil((32 + 2*clog2(verts)) / 4): 10 for two-triangle cards.
//  Emit: 4 steps per output beat (buffer read, multiply, round/saturate, hold).
//  Reset is synchronous, active low; no input is taken while a kept card is in the
//  divider or being emitted, and a stalled output beat holds the block in emit.
module leaf_card_thinner #(
    parameter int CARD_TRIANGLES = lct_pkg::CARD_TRIANGLES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lct_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lct_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [lct_pkg::POS_W-1:0]     i_pos_x,
    input  logic signed [lct_pkg::POS_W-1:0]     i_pos_y,
    input  logic signed [lct_pkg::POS_W-1:0]     i_pos_z,
    input  logic signed [lct_pkg::NRM_W-1:0]     i_norm_x,
    input  logic signed [lct_pkg::NRM_W-1:0]     i_norm_y,
    input  logic signed [lct_pkg::NRM_W-1:0]     i_norm_z,
    input  logic signed [lct_pkg::TEX_W-1:0]     i_tex_u,
    input  logic signed [lct_pkg::TEX_W-1:0]     i_tex_v,
    input  logic                                 i_part_start,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [lct_pkg::POS_W-1:0]     o_out_x,
    output logic signed [lct_pkg::POS_W-1:0]     o_out_y,
    output logic signed [lct_pkg::POS_W-1:0]     o_out_z,
    output logic signed [lct_pkg::NRM_W-1:0]     o_out_nx,
    output logic signed [lct_pkg::NRM_W-1:0]     o_out_ny,
    output logic signed [lct_pkg::NRM_W-1:0]     o_out_nz,
    output logic signed [lct_pkg::TEX_W-1:0]     o_out_u,
    output logic signed [lct_pkg::TEX_W-1:0]     o_out_v,
    output logic                                 o_card_last
);
    import lct_pkg::*;

    localparam int SLOT_W = $clog2(3 * CARD_TRIANGLES);

    t_cmd              cmd;
    t_stat             stat;
    t_vtx              vtx_in;
    t_vtx              vtx_out;
    logic [SLOT_W-1:0] wr_addr;
    logic [SLOT_W-1:0] rd_addr;

    assign vtx_in.px = i_pos_x;
    assign vtx_in.py = i_pos_y;
    assign vtx_in.pz = i_pos_z;
    assign vtx_in.nx = i_norm_x;
    assign vtx_in.ny = i_norm_y;
    assign vtx_in.nz = i_norm_z;
    assign vtx_in.u  = i_tex_u;
    assign vtx_in.v  = i_tex_v;

    lct_ctrl #(
        .CARD_TRIANGLES (CARD_TRIANGLES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_part_start (i_part_start),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cmd        (cmd),
        .i_stat       (stat),
        .o_wr_addr    (wr_addr),
        .o_rd_addr    (rd_addr)
    );

    lct_datapath #(
        .CARD_TRIANGLES (CARD_TRIANGLES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_wr_addr    (wr_addr),
        .i_rd_addr    (rd_addr),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_vtx        (vtx_in),
        .i_part_start (i_part_start),
        .o_vtx        (vtx_out),
        .o_last       (o_card_last)
    );

    assign o_out_x  = vtx_out.px;
    assign o_out_y  = vtx_out.py;
    assign o_out_z  = vtx_out.pz;
    assign o_out_nx = vtx_out.nx;
    assign o_out_ny = vtx_out.ny;
    assign o_out_nz = vtx_out.nz;
    assign o_out_u  = vtx_out.u;
    assign o_out_v  = vtx_out.v;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for leaf_card_thinner: directed card table, then randomized parts.
module tb_top;
    import lct_pkg::*;

    localparam int CARD_VERTS  = 3 * CARD_TRIANGLES_DEF;
    localparam int SETTLE      = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int DIR_ROWS    = 23;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic signed [TEX_W-1:0] u;
        logic signed [TEX_W-1:0] v;
        logic                    last;
    } t_grown_vtx;

    // Position that the card must emit for this vertex, when fixed by the table.
    typedef struct packed {
        logic                    on;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_pin;

    typedef enum logic {ROW_VTX, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  val;
        logic                   ps;
        logic                   same_out;
        t_vtx                   vtx;
    } t_dir_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic signed [POS_W-1:0]      i_pos_x = '0;
    logic signed [POS_W-1:0]      i_pos_y = '0;
    logic signed [POS_W-1:0]      i_pos_z = '0;
    logic signed [NRM_W-1:0]      i_norm_x = '0;
    logic signed [NRM_W-1:0]      i_norm_y = '0;
    logic signed [NRM_W-1:0]      i_norm_z = '0;
    logic signed [TEX_W-1:0]      i_tex_u = '0;
    logic signed [TEX_W-1:0]      i_tex_v = '0;
    logic                         i_part_start = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic signed [POS_W-1:0]      o_out_x;
    logic signed [POS_W-1:0]      o_out_y;
    logic signed [POS_W-1:0]      o_out_z;
    logic signed [NRM_W-1:0]      o_out_nx;
    logic signed [NRM_W-1:0]      o_out_ny;
    logic signed [NRM_W-1:0]      o_out_nz;
    logic signed [TEX_W-1:0]      o_out_u;
    logic signed [TEX_W-1:0]      o_out_v;
    logic                         o_card_last;

    leaf_card_thinner dut (.*);

    always #4 i_clk = ~i_clk;

    // Predictor state
    logic [RATE_W-1:0]   keep_rate_q = KEEP_RATE_RST;
    logic [GROW_W-1:0]   grow_q = GROW_RST;
    t_vtx                card_buf [CARD_VERTS];
    t_pin                pin_buf [CARD_VERTS];
    logic signed [34:0]  sum_px = '0;
    logic signed [34:0]  sum_py = '0;
    logic signed [34:0]  sum_pz = '0;
    logic [RATE_W-1:0]   keep_acc = '0;
    int unsigned         slot_q = 0;

    t_grown_vtx          grown_verts_q [$];

    int unsigned mismatches = 0;
    int unsigned n_vtx_in = 0;
    int unsigned n_vtx_out = 0;
    int unsigned n_cards_kept = 0;
    int unsigned n_reg_writes = 0;
    int unsigned send_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    bit          hold_req = 1'b0;
    int unsigned quiet_cycles = 0;

    function automatic logic signed [POS_W-1:0] grow_about_mid(
        logic signed [POS_W-1:0] p, logic signed [34:0] sum, logic [GROW_W-1:0] g);
        longint mid;
        longint d;
        longint s;
        longint r;
        mid = longint'(sum) / longint'(CARD_VERTS);
        if ((longint'(sum) % longint'(CARD_VERTS)) != 0 && sum < 0)
            mid = mid - 1;
        d = longint'(p) - mid;
        s = (d * longint'({1'b0, g}) + 64'sd4096) >>> GROW_FRAC;
        r = mid + s;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[POS_W-1:0];
    endfunction

    function automatic void clear_card();
        sum_px = '0;
        sum_py = '0;
        sum_pz = '0;
        slot_q = 0;
    endfunction

    task automatic thin_and_grow(input t_vtx v, input logic ps, input t_pin pin);
        t_grown_vtx         beat;
        logic [RATE_W-1:0]  rate;
        if (ps) begin
            keep_acc = '0;
            clear_card();
        end
        card_buf[slot_q] = v;
        pin_buf[slot_q]  = pin;
        sum_px = sum_px + 35'(v.px);
        sum_py = sum_py + 35'(v.py);
        sum_pz = sum_pz + 35'(v.pz);
        if (slot_q + 1 < CARD_VERTS) begin
            slot_q = slot_q + 1;
            return;
        end
        rate = (keep_rate_q > ONE_Q16) ? ONE_Q16 : keep_rate_q;
        keep_acc = keep_acc + rate;
        if (keep_acc < ONE_Q16) begin
            clear_card();
            return;
        end
        keep_acc = keep_acc - ONE_Q16;
        for (int k = 0; k < CARD_VERTS; k++) begin
            beat.x  = pin_buf[k].on ? pin_buf[k].x : grow_about_mid(card_buf[k].px, sum_px, grow_q);
            beat.y  = pin_buf[k].on ? pin_buf[k].y : grow_about_mid(card_buf[k].py, sum_py, grow_q);
            beat.z  = pin_buf[k].on ? pin_buf[k].z : grow_about_mid(card_buf[k].pz, sum_pz, grow_q);
            beat.nx = card_buf[k].nx;
            beat.ny = card_buf[k].ny;
            beat.nz = card_buf[k].nz;
            beat.u  = card_buf[k].u;
            beat.v  = card_buf[k].v;
            beat.last = (k == CARD_VERTS - 1);
            grown_verts_q = {grown_verts_q, beat};
        end
        n_cards_kept++;
        clear_card();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : out_check
        t_grown_vtx want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_vtx_out++;
            if (grown_verts_q.size() == 0) begin
                $display("%0t unexpected beat: expected none, actual x=%h y=%h z=%h last=%b",
                         $time, o_out_x, o_out_y, o_out_z, o_card_last);
                mismatches++;
            end else begin
                want = grown_verts_q.pop_front();
                check_field("x", want.x, o_out_x);
                check_field("y", want.y, o_out_y);
                check_field("z", want.z, o_out_z);
                check_field("nx", 32'(want.nx), 32'(o_out_nx));
                check_field("ny", 32'(want.ny), 32'(o_out_ny));
                check_field("nz", 32'(want.nz), 32'(o_out_nz));
                check_field("u", 32'(want.u), 32'(o_out_u));
                check_field("v", 32'(want.v), 32'(o_out_v));
                check_field("card_last", 32'(want.last), 32'(o_card_last));
            end
        end
    end

    // Output side: random stalls, plus one long hold on request
    int unsigned hold_cnt = 0;
    bit          hold_taken = 1'b0;
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            i_out_ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_taken) begin
            i_out_ready <= 1'b0;
            hold_cnt <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t no beat moved for %0d cycles", $time, quiet_cycles);
            $display("FAIL leaf_card_thinner");
            $finish;
        end
    end

    task automatic send_vertex(input t_vtx v, input logic ps, input t_pin pin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_pos_x      <= v.px;
        i_pos_y      <= v.py;
        i_pos_z      <= v.pz;
        i_norm_x     <= v.nx;
        i_norm_y     <= v.ny;
        i_norm_z     <= v.nz;
        i_tex_u      <= v.u;
        i_tex_v      <= v.v;
        i_part_start <= ps;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        thin_and_grow(v, ps, pin);
        n_vtx_in++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (grown_verts_q.size() != 0);
    endtask

    // Block idle: all results out, and time for a dropped card to finish
    task automatic settle_block();
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_KEEP_RATE)
            keep_rate_q = val[RATE_W-1:0];
        else
            grow_q = val[GROW_W-1:0];
        n_reg_writes++;
        @(posedge i_clk);
    endtask

    function automatic t_dir_row vrow(logic ps, logic same, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z, logic [15:0] nx, logic [15:0] ny,
                                      logic [15:0] nz, logic [15:0] tu, logic [15:0] tv);
        t_dir_row r;
        r = '0;
        r.kind     = ROW_VTX;
        r.ps       = ps;
        r.same_out = same;
        r.vtx      = '{px: x, py: y, pz: z, nx: nx, ny: ny, nz: nz, u: tu, v: tv};
        return r;
    endfunction

    function automatic t_dir_row crow(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_dir_row r;
        r = '0;
        r.kind = ROW_REG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    t_dir_row dir_tab [DIR_ROWS];

    initial begin : stimulus
        t_vtx               vx;
        t_pin               pin;
        int unsigned        budget;
        int unsigned        sent_ph;
        int unsigned        n_cards;
        int unsigned        nv;
        bit                 mid_drain;
        bit                 long_hold;
        bit                 cut;
        bit                 tail_cut;
        bit                 wild;
        bit                 has_tex;
        logic [31:0]        ctr_x;
        logic [31:0]        ctr_y;
        logic [31:0]        ctr_z;
        logic [CFG_DATA_W-1:0] rate;
        logic [CFG_DATA_W-1:0] grow;

        // same_out rows: with unit grow, or saturated extremes, or a flat card, the
        // card comes back unchanged
        dir_tab = '{
            crow(CFG_KEEP_RATE, 17'h1FFFF),
            vrow(1, 1, 32'h7FFFFFFF, 32'h80000000, 32'h00000000,
                 16'h4000, 16'hC000, 16'h0000, 16'h7FFF, 16'h8000),
            vrow(0, 1, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF,
                 16'hC000, 16'h4000, 16'hFFFF, 16'h8000, 16'h7FFF),
            vrow(0, 1, 32'h00000000, 32'h00000001, 32'h7FFFFFFF,
                 16'h0001, 16'hFFFF, 16'h4000, 16'h0000, 16'hFFFF),
            vrow(0, 1, 32'hFFFFFFFF, 32'h00000000, 32'h80000000,
                 16'h0000, 16'h0000, 16'hC000, 16'hFFFF, 16'h0000),
            vrow(0, 1, 32'h00010000, 32'hFFFF0000, 32'h55555555,
                 16'h2AAA, 16'hD555, 16'h1555, 16'h5555, 16'hAAAA),
            vrow(0, 1, 32'hAAAAAAAA, 32'h55555555, 32'h00000001,
                 16'hD556, 16'h2AAB, 16'hEAAB, 16'hAAAA, 16'h5555),
            crow(CFG_GROW, 17'h0FFFF),
            vrow(1, 0, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F,
                 16'h0100, 16'h0200, 16'h0300, 16'h1234, 16'h4321),
            vrow(0, 0, 32'hF0F0F0F0, 32'h00FF00FF, 32'hFF00FF00,
                 16'hFF00, 16'hFE00, 16'hFD00, 16'h0F0F, 16'hF0F0),
            vrow(1, 1, 32'h7FFFFFFF, 32'h80000000, 32'h00000000,
                 16'h4000, 16'h0000, 16'h0000, 16'h1000, 16'h2000),
            vrow(0, 1, 32'h80000000, 32'h7FFFFFFF, 32'h00000000,
                 16'h0000, 16'h4000, 16'h0000, 16'h3000, 16'h4000),
            vrow(0, 1, 32'h7FFFFFFF, 32'h80000000, 32'h00000000,
                 16'h0000, 16'h0000, 16'h4000, 16'h5000, 16'h6000),
            vrow(0, 1, 32'h80000000, 32'h7FFFFFFF, 32'h00000000,
                 16'hC000, 16'h0000, 16'h0000, 16'h7000, 16'h8000),
            vrow(0, 1, 32'h7FFFFFFF, 32'h80000000, 32'h00000000,
                 16'h0000, 16'hC000, 16'h0000, 16'h9000, 16'hA000),
            vrow(0, 1, 32'h80000000, 32'h7FFFFFFF, 32'h00000000,
                 16'h0000, 16'h0000, 16'hC000, 16'hB000, 16'hC000),
            crow(CFG_KEEP_RATE, 17'h00000),
            vrow(1, 0, 32'h00100000, 32'h00200000, 32'h00300000,
                 16'h0010, 16'h0020, 16'h0030, 16'h0001, 16'h0002),
            vrow(0, 0, 32'h00400000, 32'h00500000, 32'h00600000,
                 16'h0040, 16'h0050, 16'h0060, 16'h0003, 16'h0004),
            vrow(0, 0, 32'h00700000, 32'h00800000, 32'h00900000,
                 16'h0070, 16'h0080, 16'h0090, 16'h0005, 16'h0006),
            vrow(0, 0, 32'hFFA00000, 32'hFFB00000, 32'hFFC00000,
                 16'hFFA0, 16'hFFB0, 16'hFFC0, 16'h0007, 16'h0008),
            vrow(0, 0, 32'hFFD00000, 32'hFFE00000, 32'hFFF00000,
                 16'hFFD0, 16'hFFE0, 16'hFFF0, 16'h0009, 16'h000A),
            vrow(0, 0, 32'h01000000, 32'h02000000, 32'h03000000,
                 16'h0100, 16'h0200, 16'h0300, 16'h000B, 16'h000C)
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_tab[r].kind == ROW_REG) begin
                settle_block();
                write_reg(dir_tab[r].idx, dir_tab[r].val);
            end else begin
                pin = '{on: dir_tab[r].same_out, x: dir_tab[r].vtx.px,
                        y: dir_tab[r].vtx.py, z: dir_tab[r].vtx.pz};
                send_vertex(dir_tab[r].vtx, dir_tab[r].ps, pin);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            mid_drain = 1'b0;
            long_hold = 1'b0;
            budget = 18;
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    rate = ONE_Q16;
                    grow = 17'd11585;
                end
                1: begin
                    send_idle_pct = 67;
                    rate = 17'd32768;
                    grow = 17'h0FFFF;
                    mid_drain = 1'b1;
                end
                2: begin
                    send_idle_pct = 0;
                    rate = 17'd43690;
                    grow = 17'd0;
                end
                3: begin
                    send_idle_pct = 38;
                    rate = 17'($urandom_range(65536, 1));
                    grow = 17'($urandom_range(65535));
                end
                4: begin
                    send_idle_pct = 0;
                    rate = ONE_Q16;
                    grow = 17'd8192 + 17'($urandom_range(8191));
                    long_hold = 1'b1;
                end
                default: begin
                    send_idle_pct = 38;
                    rate = 17'd0;
                    grow = 17'($urandom_range(65535));
                    budget = 6;
                end
            endcase
            settle_block();
            sink_stall_pct <= (ph == 2) ? 67 : (ph == 3 || ph == 5) ? 38 : 0;
            write_reg(CFG_KEEP_RATE, rate);
            write_reg(CFG_GROW, grow);
            if (long_hold)
                hold_req <= 1'b1;

            sent_ph = 0;
            tail_cut = 1'b0;
            while (sent_ph < budget || tail_cut) begin
                if (mid_drain && sent_ph >= budget / 2) begin
                    drain_results();
                    mid_drain = 1'b0;
                end
                n_cards = $urandom_range(4, 1);
                has_tex = ($urandom_range(3) != 0);
                cut = 1'b0;
                for (int c = 0; c < n_cards && !cut; c++) begin
                    nv = CARD_VERTS;
                    if ($urandom_range(7) == 0) begin
                        nv = $urandom_range(CARD_VERTS - 1, 1);
                        cut = 1'b1;
                    end
                    wild  = ($urandom_range(3) == 0);
                    ctr_x = $urandom;
                    ctr_y = $urandom;
                    ctr_z = $urandom;
                    for (int k = 0; k < nv; k++) begin
                        vx.px = wild ? $urandom : ctr_x + ($urandom_range(2**21) - 2**20);
                        vx.py = wild ? $urandom : ctr_y + ($urandom_range(2**21) - 2**20);
                        vx.pz = wild ? $urandom : ctr_z + ($urandom_range(2**21) - 2**20);
                        vx.nx = 16'($urandom_range(32768) - 16384);
                        vx.ny = 16'($urandom_range(32768) - 16384);
                        vx.nz = 16'($urandom_range(32768) - 16384);
                        vx.u  = has_tex ? 16'($urandom) : 16'd0;
                        vx.v  = has_tex ? 16'($urandom) : 16'd0;
                        send_vertex(vx, (c == 0 && k == 0), '0);
                        sent_ph++;
                    end
                end
                tail_cut = cut;
            end
        end

        settle_block();
        $display("Run covered %0d vertices in, %0d out, %0d cards kept, %0d register writes",
                 n_vtx_in, n_vtx_out, n_cards_kept, n_reg_writes);
        $display("with sender gaps, output stalls, one long output hold and clipped cards");
        if (mismatches == 0)
            $display("PASS leaf_card_thinner");
        else
            $display("FAIL leaf_card_thinner");
        $finish;
    end

endmodule
